### src/lz78_pkg.sv
// lz78_pkg: shared constants and the dictionary entry type of the lz78 token decoder
// no dependencies; imported by lz78_dict, lz78_stack, lz78_token_decoder and the bench
`default_nettype none

package lz78_pkg;

	localparam int DICT_DEPTH  = 4096;
	localparam int DICT_AW     = $clog2(DICT_DEPTH);
	localparam int CNT_W       = $clog2(DICT_DEPTH + 1);
	localparam int MAX_PHRASE  = 63;
	localparam int LEN_W       = $clog2(MAX_PHRASE + 1);
	localparam int STACK_DEPTH = 64;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int IDX_W       = 16;
	localparam int BYTE_W      = 8;

	// one dictionary entry: parent entry, last byte, phrase length
	typedef struct packed {
		logic [DICT_AW-1:0] parent;
		logic [BYTE_W-1:0]  data;
		logic [LEN_W-1:0]   len;
	} entry_t;

endpackage

`default_nettype wire

### src/lz78_dict.sv
// lz78_dict: dictionary memory, one write port and one registered read port
// depends on lz78_pkg for the entry type and depth
`default_nettype none

module lz78_dict import lz78_pkg::*; (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [DICT_AW-1:0] waddr,
	input  wire entry_t             wdata,
	input  wire logic [DICT_AW-1:0] raddr,
	output entry_t                  rdata
);

	entry_t mem_q [DICT_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### src/lz78_stack.sv
// lz78_stack: phrase rebuild buffer, one write port and one registered read port
// depends on lz78_pkg for the depth and byte width
`default_nettype none

module lz78_stack import lz78_pkg::*; (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [STK_AW-1:0] waddr,
	input  wire logic [BYTE_W-1:0] wdata,
	input  wire logic [STK_AW-1:0] raddr,
	output logic      [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem_q [STACK_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### src/lz78_token_decoder.sv
// lz78_token_decoder: top level, token sequencer around the dictionary and phrase stack
// depends on lz78_pkg, lz78_dict and lz78_stack
// per token: request, lookup of its entry, chain reads, prime, phrase bytes, literal;
// a literal-only token goes from its request to its literal, and a rejection at request
// or at dictionary lookup gives one error result; a new token is taken only in idle,
// after the last one's literal or error result is loaded; output stalls hold the sequencer
// reset: arst_n clears entry count, halt flag, sequencer and output valid; memories are not cleared
`default_nettype none

module lz78_token_decoder import lz78_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // [15:0] phrase_index, [23:16] literal_byte
	input  wire logic        s_tuser,  // [0] start_of_message
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata,  // [7:0] out_byte
	output logic             m_tlast,  // last_of_token
	output logic             m_tuser   // [0] decode_error
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOKUP = 3'd1;
	localparam logic [2:0] ST_WALK   = 3'd2;
	localparam logic [2:0] ST_PRIME  = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;
	localparam logic [2:0] ST_LIT    = 3'd5;
	localparam logic [2:0] ST_ERR    = 3'd6;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic               halted_q;
	logic [DICT_AW-1:0] ref_q;
	logic [BYTE_W-1:0]  lit_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   k_q;
	logic [LEN_W-1:0]   pos_q;
	logic [BYTE_W-1:0]  out_data_q;
	logic               out_last_q;
	logic               out_err_q;
	logic               out_valid_q;

	logic               accept;
	logic [IDX_W-1:0]   idx;
	logic [BYTE_W-1:0]  lit;
	logic [IDX_W-1:0]   ref_full;
	logic [CNT_W-1:0]   cnt_eff;
	logic               halt_eff;
	logic               bad_idx;
	logic               dict_full;
	logic               too_long;
	logic               load;

	logic               dict_we;
	entry_t             dict_wdata;
	logic [DICT_AW-1:0] dict_raddr;
	entry_t             dict_rdata;
	logic               stk_we;
	logic [STK_AW-1:0]  stk_waddr;
	logic [STK_AW-1:0]  stk_raddr;
	logic [BYTE_W-1:0]  stk_rdata;

	// request decode
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign idx      = s_tdata[IDX_W-1:0];
	assign lit      = s_tdata[IDX_W+BYTE_W-1:IDX_W];
	assign ref_full = idx - IDX_W'(1);
	assign cnt_eff  = s_tuser ? '0 : count_q;
	assign halt_eff = s_tuser ? 1'b0 : halted_q;
	assign bad_idx  = (idx != '0) && (32'(ref_full) >= 32'(cnt_eff));
	assign dict_full = (state_q == ST_IDLE) ? (32'(cnt_eff) >= 32'(DICT_DEPTH))
	                                        : (32'(count_q) >= 32'(DICT_DEPTH));
	assign too_long = (32'(dict_rdata.len) + 32'd1) > 32'(MAX_PHRASE);

	// output register may take a new result
	assign load = !out_valid_q || m_tready;

	// dictionary read address: the token's entry, then each parent in turn
	always_comb begin
		unique case (state_q)
			ST_IDLE:            dict_raddr = ref_full[DICT_AW-1:0];
			ST_LOOKUP, ST_WALK: dict_raddr = dict_rdata.parent;
			default:            dict_raddr = '0;
		endcase
	end

	// dictionary write of the new entry when the literal goes out
	assign dict_we           = (state_q == ST_LIT) && load;
	assign dict_wdata.parent = ref_q;
	assign dict_wdata.data   = lit_q;
	assign dict_wdata.len    = LEN_W'(len_q + LEN_W'(1));

	// phrase stack is filled from the end, one chain step per cycle
	assign stk_we    = ((state_q == ST_LOOKUP) && !dict_full && !too_long) ||
	                   (state_q == ST_WALK);
	assign stk_waddr = (state_q == ST_LOOKUP) ? STK_AW'(dict_rdata.len - LEN_W'(1))
	                                          : STK_AW'(k_q - LEN_W'(1));

	// stack read runs one address ahead of the output register
	always_comb begin
		if (state_q == ST_EMIT && load) begin
			stk_raddr = STK_AW'(pos_q + LEN_W'(1));
		end else if (state_q == ST_EMIT) begin
			stk_raddr = STK_AW'(pos_q);
		end else begin
			stk_raddr = '0;
		end
	end

	lz78_dict u_dict (
		.clk   (clk),
		.we    (dict_we),
		.waddr (count_q[DICT_AW-1:0]),
		.wdata (dict_wdata),
		.raddr (dict_raddr),
		.rdata (dict_rdata)
	);

	lz78_stack u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (dict_rdata.data),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// token sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			halted_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= cnt_eff;
						if (halt_eff) begin
							halted_q <= 1'b1;
							state_q  <= ST_ERR;
						end else if (bad_idx) begin
							halted_q <= 1'b1;
							state_q  <= ST_ERR;
						end else if (idx == '0) begin
							if (dict_full) begin
								halted_q <= 1'b1;
								state_q  <= ST_ERR;
							end else begin
								halted_q <= 1'b0;
								state_q  <= ST_LIT;
							end
						end else begin
							halted_q <= 1'b0;
							state_q  <= ST_LOOKUP;
						end
					end
				end
				ST_LOOKUP: begin
					if (dict_full || too_long) begin
						halted_q <= 1'b1;
						state_q  <= ST_ERR;
					end else if (dict_rdata.len == LEN_W'(1)) begin
						state_q <= ST_PRIME;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (k_q == LEN_W'(1)) begin
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load && pos_q == LEN_W'(len_q - LEN_W'(1))) begin
						state_q <= ST_LIT;
					end
				end
				ST_LIT: begin
					if (load) begin
						count_q <= CNT_W'(count_q + CNT_W'(1));
						state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// token payload and walk counters
	always_ff @(posedge clk) begin
		if (accept) begin
			ref_q <= (idx == '0) ? '0 : ref_full[DICT_AW-1:0];
			lit_q <= lit;
			len_q <= '0;
		end
		if (state_q == ST_LOOKUP) begin
			len_q <= dict_rdata.len;
			k_q   <= LEN_W'(dict_rdata.len - LEN_W'(1));
		end
		if (state_q == ST_WALK) begin
			k_q <= LEN_W'(k_q - LEN_W'(1));
		end
		if (state_q == ST_PRIME) begin
			pos_q <= '0;
		end
		if (state_q == ST_EMIT && load) begin
			pos_q <= LEN_W'(pos_q + LEN_W'(1));
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load && (state_q == ST_EMIT || state_q == ST_LIT ||
		                      state_q == ST_ERR)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			unique case (state_q)
				ST_EMIT: begin
					out_data_q <= stk_rdata;
					out_last_q <= 1'b0;
					out_err_q  <= 1'b0;
				end
				ST_LIT: begin
					out_data_q <= lit_q;
					out_last_q <= 1'b1;
					out_err_q  <= 1'b0;
				end
				ST_ERR: begin
					out_data_q <= '0;
					out_last_q <= 1'b1;
					out_err_q  <= 1'b1;
				end
				default: begin
					out_data_q <= out_data_q;
					out_last_q <= out_last_q;
					out_err_q  <= out_err_q;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

`ifndef ASSERT_OFF
	// entry count never passes the dictionary depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(DICT_DEPTH))
		else $error("entry count beyond dictionary depth");

	// an error result carries a zero byte and closes the token
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
		else $error("malformed error result");

	// a halted message rejects a request without start of message
	a_halt_err: assert property (@(posedge clk) disable iff (!arst_n)
		accept && halted_q && !s_tuser |=> state_q == ST_ERR)
		else $error("halted message did not reject request");

	// chain walk never runs with no steps left
	a_walk_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> k_q != '0)
		else $error("walk counter underflow");
`endif

endmodule

`default_nettype wire

### bench/lz78_token_decoder_tb.sv
// lz78_token_decoder_tb: self-checking bench for the lz78 token decoder, predicts every decoded
// byte from its own dictionary copy and checks the output stream under random idling on both sides
// depends on lz78_pkg and lz78_token_decoder
`default_nettype none

module lz78_token_decoder_tb;
	import lz78_pkg::*;

	localparam int RANDOM_TOKENS = 460;
	localparam int CYCLE_LIMIT   = 40000000;
	localparam int DRAIN_CYCLES  = 200;

	// one decoded output: byte, last flag, error flag
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} byte_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [15:0] phrase_index, [23:16] literal_byte
	logic        s_tuser;   // [0] start_of_message
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] out_byte
	logic        m_tlast;   // last_of_token
	logic        m_tuser;   // [0] decode_error

	// predictor state: dictionary copy and halt flag
	logic [DICT_AW-1:0] dict_parent [DICT_DEPTH];
	logic [7:0]         dict_byte [DICT_DEPTH];
	int                 dict_len [DICT_DEPTH];
	int unsigned        dict_count;
	bit                 dict_halted;

	byte_result_t expected_bytes[$];
	byte_result_t oldest;

	int  mismatch_count;
	int  tokens_sent;
	int  bytes_checked;
	int  tokens_rejected;
	int  random_sent;
	int  cycle_count;
	int  rx_stall;
	bit  tx_idle_on;
	bit  rx_idle_on;

	lz78_token_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_bytes.size());
			$display("FAIL lz78_token_decoder");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycle_count);
		mismatch_count++;
	endtask

	// rejected token: one error result, message halted
	task automatic reject_token();
		byte_result_t res;
		res.data = 8'h00;
		res.last = 1'b1;
		res.err = 1'b1;
		expected_bytes.push_back(res);
		dict_halted = 1'b1;
		tokens_rejected++;
	endtask

	// expected output bytes of one accepted token, dictionary update
	task automatic decode_token(input logic [15:0] idx, input logic [7:0] lit, input logic som);
		int unsigned  ref_entry;
		int unsigned  cur;
		int           phrase_len;
		int           k;
		logic [7:0]   rebuilt [64];
		byte_result_t res;
		ref_entry = 0;
		phrase_len = 0;
		if (som) begin
			dict_count = 0;
			dict_halted = 1'b0;
		end
		if (dict_halted) begin
			reject_token();
			return;
		end
		if (idx != 0) begin
			ref_entry = idx - 1;
			if (ref_entry >= dict_count) begin
				reject_token();
				return;
			end
			phrase_len = dict_len[ref_entry];
		end
		if (dict_count >= DICT_DEPTH || phrase_len + 1 > MAX_PHRASE) begin
			reject_token();
			return;
		end
		// walk the parent chain back to front
		cur = ref_entry;
		for (k = phrase_len; k > 0; k--) begin
			rebuilt[k-1] = dict_byte[cur];
			cur = dict_parent[cur];
		end
		for (k = 0; k < phrase_len; k++) begin
			res.data = rebuilt[k];
			res.last = 1'b0;
			res.err = 1'b0;
			expected_bytes.push_back(res);
		end
		res.data = lit;
		res.last = 1'b1;
		res.err = 1'b0;
		expected_bytes.push_back(res);
		dict_parent[dict_count] = ref_entry[DICT_AW-1:0];
		dict_byte[dict_count] = lit;
		dict_len[dict_count] = phrase_len + 1;
		dict_count++;
	endtask

	// one token request: optional gap, hold until accepted, then predict
	task automatic send_token(input logic [15:0] idx, input logic [7:0] lit, input logic som);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {lit, idx};
		s_tuser <= som;
		do
			@(posedge clk);
		while (!s_tready);
		decode_token(idx, lit, som);
		tokens_sent++;
		@(negedge clk);
	endtask

	// output stall pattern
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
			if (rx_idle_on && $urandom_range(0, 99) < 30)
				rx_stall = pick_gap();
		end
	end

	// compare each delivered byte with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("result with nothing expected", m_tdata, 0);
			end else begin
				oldest = expected_bytes.pop_front();
				bytes_checked++;
				if (m_tdata !== oldest.data)
					report_mismatch("out_byte", m_tdata, oldest.data);
				if (m_tlast !== oldest.last)
					report_mismatch("last_of_token", m_tlast, oldest.last);
				if (m_tuser !== oldest.err)
					report_mismatch("decode_error", m_tuser, oldest.err);
			end
		end
	end

	// literals, short chains, bad indexes, halted tokens and restarts
	task automatic test_directed_tokens();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_token(16'd0, 8'h00, 1'b0);
		send_token(16'd0, 8'hFF, 1'b0);
		send_token(16'd1, 8'hA5, 1'b0);
		send_token(16'd3, 8'h5A, 1'b0);
		send_token(16'd2, 8'h01, 1'b0);
		// index one past the last entry
		send_token(16'd6, 8'h77, 1'b0);
		send_token(16'd0, 8'h33, 1'b0);
		send_token(16'd1, 8'hC3, 1'b0);
		send_token(16'd0, 8'h80, 1'b1);
		send_token(16'd1, 8'h7F, 1'b0);
		send_token(16'hFFFF, 8'hFF, 1'b0);
		// reference right after a clear
		send_token(16'd1, 8'h00, 1'b1);
		send_token(16'h8000, 8'h55, 1'b1);
		send_token(16'd0, 8'hAA, 1'b1);
		send_token(16'd2, 8'h11, 1'b0);
		send_token(16'd0, 8'h3C, 1'b1);
	endtask

	// one chain up to the longest phrase, then one step too far
	task automatic test_phrase_too_long();
		int k;
		send_token(16'd0, 8'($urandom_range(0, 255)), 1'b1);
		for (k = 1; k < MAX_PHRASE; k++)
			send_token(16'(k), 8'($urandom_range(0, 255)), 1'b0);
		send_token(16'(MAX_PHRASE), 8'hE7, 1'b0);
		send_token(16'd1, 8'h42, 1'b0);
	endtask

	// fill the whole dictionary, then try to add one more entry
	task automatic test_dictionary_full();
		logic [15:0] idx;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_token(16'd0, 8'($urandom_range(0, 255)), 1'b1);
		while (dict_count < DICT_DEPTH && !dict_halted) begin
			idx = 16'd0;
			if ($urandom_range(0, 7) == 0) begin
				idx = 16'($urandom_range(1, dict_count));
				if (dict_len[idx-1] >= MAX_PHRASE - 1)
					idx = 16'd0;
			end
			send_token(idx, 8'($urandom_range(0, 255)), 1'b0);
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_token(16'(DICT_DEPTH), 8'h99, 1'b0);
		send_token(16'd0, 8'h12, 1'b0);
		send_token(16'd0, 8'h34, 1'b1);
	endtask

	// random messages: mostly valid references, some bad indexes and noise
	task automatic test_random_messages();
		int          msg_tokens;
		int          t;
		int          r;
		int          pick;
		int unsigned avail;
		logic [15:0] idx;
		logic        som;
		while (random_sent < RANDOM_TOKENS) begin
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			msg_tokens = $urandom_range(4, 60);
			for (t = 0; t < msg_tokens; t++) begin
				if (dict_halted && $urandom_range(0, 2) == 0)
					break;
				som = (t == 0);
				avail = som ? 0 : dict_count;
				r = $urandom_range(0, 99);
				if (r < 86) begin
					pick = $urandom_range(0, 9);
					if (avail == 0 || pick < 3)
						idx = 16'd0;
					else if (pick < 7)
						idx = 16'(avail);
					else
						idx = 16'($urandom_range(1, avail));
				end else if (r < 93) begin
					idx = 16'($urandom_range(avail + 1, 65535));
				end else begin
					idx = 16'($urandom);
					if (t != 0)
						som = $urandom_range(0, 7) == 0;
				end
				send_token(idx, 8'($urandom_range(0, 255)), som);
				random_sent++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		rx_stall = 0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		dict_count = 0;
		dict_halted = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_tokens();
		test_phrase_too_long();
		test_dictionary_full();
		test_random_messages();
		s_tvalid <= 1'b0;

		// drain, then watch for stray output
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("decoded %0d tokens into %0d checked results, %0d tokens rejected",
			tokens_sent, bytes_checked, tokens_rejected);
		$display("covered literals, chained phrases up to full length, bad indexes, "
			, "full dictionary, overlong phrase, halted tokens and restarts");
		if (mismatch_count == 0 && expected_bytes.size() == 0) begin
			$display("PASS lz78_token_decoder");
		end else begin
			$display("FAIL lz78_token_decoder");
		end
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
src/lz78_pkg.sv
src/lz78_dict.sv
src/lz78_stack.sv
src/lz78_token_decoder.sv
bench/lz78_token_decoder_tb.sv
